[rtl/dsgp_pkg.sv]
// Shared types, widths and codes of the drifting square-grating pixel generator.
// Used by every module of the block; depends on nothing.
package dsgp_pkg;

    // Default parameter values
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 14;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int COEF_W  = 16;
    localparam int WL_W    = 12;
    localparam int SPEED_W = 13;
    localparam int TIME_W  = 16;
    localparam int PIX_W   = 16;

    // Signed speed times unsigned frame time
    localparam int DRIFT_W = SPEED_W + TIME_W + 1;

    // Remainder bits resolved per pipeline stage
    localparam int DIV_STEP = 4;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DIRECTION_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COS_COEF       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIN_COEF       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WAVE_LENGTH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIFT_SPEED    = 3'd4;

    // Direction modes; every other code selects the general rotation
    localparam logic [MODE_W-1:0] MODE_NEG_COL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROW     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COL     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEG_ROW = 3'd3;

    // Reset values
    localparam logic [MODE_W-1:0]         RST_DIRECTION_MODE = 3'd2;
    localparam logic signed [COEF_W-1:0]  RST_COS_COEF       = 16'sd16384;
    localparam logic signed [COEF_W-1:0]  RST_SIN_COEF       = 16'sd0;
    localparam logic [WL_W-1:0]           RST_WAVE_LENGTH    = 12'd32;
    localparam logic signed [SPEED_W-1:0] RST_DRIFT_SPEED    = 13'sd0;

    localparam logic [PIX_W-1:0] PIX_WHITE = 16'hFFFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 16'h0000;

    // Settings seen by the datapath; wave_length is never zero here
    typedef struct packed {
        logic [MODE_W-1:0]         direction_mode;
        logic signed [COEF_W-1:0]  cos_coef;
        logic signed [COEF_W-1:0]  sin_coef;
        logic [WL_W-1:0]           wave_length;
        logic signed [SPEED_W-1:0] drift_speed;
    } t_cfg;

    // Width of the signed phase sum for a coordinate and fraction width
    function automatic int f_sum_width(input int coord_bits, input int frac_bits);
        int proj_w;
        proj_w = COEF_W + coord_bits + 2 - frac_bits;
        return ((proj_w > DRIFT_W) ? proj_w : DRIFT_W) + 1;
    endfunction

endpackage

[rtl/drifting_square_grating_pixel_top.sv]
// Top level of the drifting square-grating pixel generator.
// Instantiates dsgp_cfg, dsgp_proj and dsgp_mod; depends on dsgp_pkg.
//
//   port group        direction  handshake            payload
//   pixel in          in         i_valid / o_ready    i_pixel_col, i_pixel_row, i_frame_time
//   pixel out         out        o_valid / i_ready    o_pixel_value
//   register access   in         psel/penable/pready  paddr, pwdata, prdata
//
// One pixel enters and one leaves per cycle while the output is not stalled. The phase
// sum is S bits wide (31 bits at the default widths);
// the remainder stages resolve four bits of the phase each.
// Every stage holds its beat on its own, so a stall at the output fills the bubbles
// behind it first; nothing is dropped or repeated. Reset is synchronous, active low,
// and clears the stage valid bits and loads the register defaults.
module drifting_square_grating_pixel_top #(
    parameter int COORD_BITS = dsgp_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = dsgp_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsgp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dsgp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dsgp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [COORD_BITS-1:0]           i_pixel_col,
    input  logic [COORD_BITS-1:0]           i_pixel_row,
    input  logic [dsgp_pkg::TIME_W-1:0]     i_frame_time,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [dsgp_pkg::PIX_W-1:0]      o_pixel_value
);
    import dsgp_pkg::*;

    localparam int S_W = f_sum_width(COORD_BITS, FRAC_BITS);

    t_cfg                  w_cfg;
    logic                  w_mid_valid;
    logic                  w_mid_ready;
    logic signed [S_W-1:0] w_mid_sum;

    dsgp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dsgp_proj #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_col   (i_pixel_col),
        .i_row   (i_pixel_row),
        .i_time  (i_frame_time),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_sum   (w_mid_sum)
    );

    dsgp_mod #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mod (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (w_mid_valid),
        .o_ready       (w_mid_ready),
        .i_sum         (w_mid_sum),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value)
    );

endmodule

[rtl/dsgp_cfg.sv]
// APB-style register file of the grating generator.
// Depends on dsgp_pkg for register codes, reset values and the t_cfg struct.
module dsgp_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dsgp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dsgp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dsgp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output dsgp_pkg::t_cfg                       o_cfg
);
    import dsgp_pkg::*;

    logic [MODE_W-1:0]         r_mode;
    logic signed [COEF_W-1:0]  r_cos;
    logic signed [COEF_W-1:0]  r_sin;
    logic [WL_W-1:0]           r_wl;
    logic signed [SPEED_W-1:0] r_speed;
    logic                      w_wr;
    logic [REG_IDX_W-1:0]      w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_DIRECTION_MODE;
            r_cos   <= RST_COS_COEF;
            r_sin   <= RST_SIN_COEF;
            r_wl    <= RST_WAVE_LENGTH;
            r_speed <= RST_DRIFT_SPEED;
        end else if (w_wr) begin
            case (w_idx)
                REG_DIRECTION_MODE: r_mode  <= pwdata[MODE_W-1:0];
                REG_COS_COEF:       r_cos   <= pwdata[COEF_W-1:0];
                REG_SIN_COEF:       r_sin   <= pwdata[COEF_W-1:0];
                REG_WAVE_LENGTH:    r_wl    <= pwdata[WL_W-1:0];
                REG_DRIFT_SPEED:    r_speed <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DIRECTION_MODE: prdata = APB_DATA_W'(r_mode);
            REG_COS_COEF:       prdata = APB_DATA_W'($unsigned(r_cos));
            REG_SIN_COEF:       prdata = APB_DATA_W'($unsigned(r_sin));
            REG_WAVE_LENGTH:    prdata = APB_DATA_W'(r_wl);
            REG_DRIFT_SPEED:    prdata = APB_DATA_W'($unsigned(r_speed));
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.direction_mode = r_mode;
        o_cfg.cos_coef       = r_cos;
        o_cfg.sin_coef       = r_sin;
        // a zero period behaves as a period of one
        o_cfg.wave_length    = (r_wl == '0) ? WL_W'(1) : r_wl;
        o_cfg.drift_speed    = r_speed;
    end

endmodule

[rtl/dsgp_proj.sv]
// Front pipeline: projects the pixel onto the drift direction and adds the drift.
// Four stages: multiply, sum, truncate toward zero, add drift. Depends on dsgp_pkg.
module dsgp_proj #(
    parameter int COORD_BITS = dsgp_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = dsgp_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dsgp_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COORD_BITS-1:0]        i_col,
    input  logic [COORD_BITS-1:0]        i_row,
    input  logic [dsgp_pkg::TIME_W-1:0]  i_time,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [dsgp_pkg::f_sum_width(COORD_BITS, FRAC_BITS)-1:0] o_sum
);
    import dsgp_pkg::*;

    localparam int PROD_W = COEF_W + COORD_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int PROJ_W = ACC_W - FRAC_BITS;
    localparam int S_W    = f_sum_width(COORD_BITS, FRAC_BITS);
    localparam int NSTG   = 4;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // stage 1
    logic signed [PROD_W-1:0]  r1_pc;
    logic signed [PROD_W-1:0]  r1_ps;
    logic signed [DRIFT_W-1:0] r1_dr;
    logic [COORD_BITS-1:0]     r1_col;
    logic [COORD_BITS-1:0]     r1_row;
    // stage 2
    logic signed [ACC_W-1:0]   r2_acc;
    logic signed [PROJ_W-1:0]  r2_exact;
    logic                      r2_gen;
    logic signed [DRIFT_W-1:0] r2_dr;
    // stage 3
    logic signed [PROJ_W-1:0]  r3_proj;
    logic signed [DRIFT_W-1:0] r3_dr;
    // stage 4
    logic signed [S_W-1:0]     r4_sum;

    logic signed [PROJ_W-1:0]  w_col;
    logic signed [PROJ_W-1:0]  w_row;
    logic signed [PROJ_W-1:0]  n_exact;
    logic                      n_gen;
    logic signed [PROJ_W-1:0]  w_floor;
    logic                      w_round_up;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_sum   = r4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 1: the three products
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_pc  <= PROD_W'(i_cfg.cos_coef) * PROD_W'($signed({1'b0, i_col}));
            r1_ps  <= PROD_W'(i_cfg.sin_coef) * PROD_W'($signed({1'b0, i_row}));
            r1_dr  <= DRIFT_W'(i_cfg.drift_speed) * DRIFT_W'($signed({1'b0, i_time}));
            r1_col <= i_col;
            r1_row <= i_row;
        end
    end

    // stage 2: rotation sum and the exact right-angle forms
    assign w_col = PROJ_W'($signed({1'b0, r1_col}));
    assign w_row = PROJ_W'($signed({1'b0, r1_row}));

    always_comb begin
        n_gen = 1'b0;
        case (i_cfg.direction_mode)
            MODE_NEG_COL: n_exact = -w_col;
            MODE_ROW:     n_exact = w_row;
            MODE_COL:     n_exact = w_col;
            MODE_NEG_ROW: n_exact = -w_row;
            default: begin
                n_exact = '0;
                n_gen   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_acc   <= ACC_W'(r1_pc) + ACC_W'(r1_ps);
            r2_exact <= n_exact;
            r2_gen   <= n_gen;
            r2_dr    <= r1_dr;
        end
    end

    // stage 3: drop the fraction, rounding toward zero
    assign w_floor    = r2_acc[ACC_W-1:FRAC_BITS];
    assign w_round_up = r2_acc[ACC_W-1] && (|r2_acc[FRAC_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_proj <= r2_gen ? (w_floor + PROJ_W'(w_round_up)) : r2_exact;
            r3_dr   <= r2_dr;
        end
    end

    // stage 4: add the drift
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_sum <= S_W'(r3_proj) + S_W'(r3_dr);
        end
    end

endmodule

[rtl/dsgp_mod.sv]
// Back pipeline: non-negative remainder by the wavelength and the stripe decision.
// Magnitude stage, DIV_STEP remainder bits per stage, then the output register.
// Depends on dsgp_pkg.
module dsgp_mod #(
    parameter int COORD_BITS = dsgp_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = dsgp_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dsgp_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [dsgp_pkg::f_sum_width(COORD_BITS, FRAC_BITS)-1:0] i_sum,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dsgp_pkg::PIX_W-1:0]   o_pixel_value
);
    import dsgp_pkg::*;

    localparam int S_W   = f_sum_width(COORD_BITS, FRAC_BITS);
    localparam int NDIV  = (S_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DVD_W = NDIV * DIV_STEP;
    localparam int NSTG  = NDIV + 2;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_en;

    logic [S_W-1:0]   r_mag;
    logic             r_mag_neg;

    logic [WL_W-1:0]  r_rem [NDIV];
    logic [DVD_W-1:0] r_dvd [NDIV];
    logic             r_neg [NDIV];

    logic [PIX_W-1:0] r_pix;
    logic             w_nz;
    logic [WL_W:0]    w_rem2;
    logic [WL_W:0]    w_wl;
    logic             w_white;

    // Shift DIV_STEP dividend bits into the running remainder.
    function automatic logic [WL_W-1:0] f_div_step(
        input logic [WL_W-1:0]     rem,
        input logic [DIV_STEP-1:0] bits,
        input logic [WL_W-1:0]     wl
    );
        logic [WL_W:0]   acc;
        logic [WL_W-1:0] cur;
        cur = rem;
        for (int i = DIV_STEP - 1; i >= 0; i--) begin
            acc = {cur, bits[i]};
            if (acc >= {1'b0, wl}) begin
                acc = acc - {1'b0, wl};
            end
            cur = acc[WL_W-1:0];
        end
        return cur;
    endfunction

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign o_ready       = w_en[0];
    assign o_valid       = r_vld[NSTG-1];
    assign o_pixel_value = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // magnitude and sign of the phase
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mag_neg <= i_sum[S_W-1];
            r_mag     <= i_sum[S_W-1] ? (~$unsigned(i_sum) + S_W'(1)) : $unsigned(i_sum);
        end
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [WL_W-1:0]  w_rem_in;
        logic [DVD_W-1:0] w_dvd_in;
        logic             w_neg_in;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_dvd_in = DVD_W'(r_mag);
            assign w_neg_in = r_mag_neg;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_dvd_in = r_dvd[k-1];
            assign w_neg_in = r_neg[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k+1]) begin
                r_rem[k] <= f_div_step(w_rem_in, w_dvd_in[DVD_W-1 -: DIV_STEP],
                                       i_cfg.wave_length);
                r_dvd[k] <= w_dvd_in << DIV_STEP;
                r_neg[k] <= w_neg_in;
            end
        end
    end

    // A negative phase with remainder m folds to wl - m; 2(wl - m) <= wl is 2m >= wl.
    assign w_nz    = |r_rem[NDIV-1];
    assign w_rem2  = {r_rem[NDIV-1], 1'b0};
    assign w_wl    = {1'b0, i_cfg.wave_length};
    assign w_white = (r_neg[NDIV-1] && w_nz) ? (w_rem2 >= w_wl) : (w_rem2 <= w_wl);

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_pix <= w_white ? PIX_WHITE : PIX_BLACK;
        end
    end

endmodule

[tb/sv/drifting_square_grating_pixel_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of drifting_square_grating_pixel_top: APB register setup,
// random pixel beats with stalls on both sides, per-beat check of the grating pixel.
// Depends on dsgp_pkg and the RTL of drifting_square_grating_pixel_top.
module drifting_square_grating_pixel_top_tb;
    import dsgp_pkg::*;

    localparam int COORD_BITS   = DEF_COORD_BITS;
    localparam int FRAC_BITS    = DEF_FRAC_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int ITEM_TARGET  = 1300;
    localparam int TAIL_START   = 1100;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_GENERAL = 3'd4;
    localparam logic [MODE_W-1:0]    MODE_LAST    = 3'd7;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [TIME_W-1:0]     TIME_MAX  = '1;

    typedef struct {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [TIME_W-1:0]     frame;
        logic [PIX_W-1:0]      pixel;
    } t_pixel_expect;

    typedef struct {
        logic [MODE_W-1:0] mode;
        int                cos_q;
        int                sin_q;
        int                wave_len;
        int                speed;
    } t_grating_settings;

    class t_pixel_scoreboard;
        logic [MODE_W-1:0]         mode;
        logic signed [COEF_W-1:0]  cos_q;
        logic signed [COEF_W-1:0]  sin_q;
        logic [WL_W-1:0]           wave_len;
        logic signed [SPEED_W-1:0] speed;
        t_pixel_expect             expected_pixels[$];
        int                        fail_count;

        function new();
            mode       = RST_DIRECTION_MODE;
            cos_q      = RST_COS_COEF;
            sin_q      = RST_SIN_COEF;
            wave_len   = RST_WAVE_LENGTH;
            speed      = RST_DRIFT_SPEED;
            fail_count = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_DIRECTION_MODE: mode     = data[MODE_W-1:0];
                REG_COS_COEF:       cos_q    = data[COEF_W-1:0];
                REG_SIN_COEF:       sin_q    = data[COEF_W-1:0];
                REG_WAVE_LENGTH:    wave_len = data[WL_W-1:0];
                REG_DRIFT_SPEED:    speed    = data[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] grating_pixel(logic [COORD_BITS-1:0] col,
                                                 logic [COORD_BITS-1:0] row,
                                                 logic [TIME_W-1:0] frame);
            longint period, proj, acc, phase, rem;
            period = wave_len;
            if (period == 0) begin
                period = 1;
            end
            case (mode)
                MODE_NEG_COL: proj = -longint'(col);
                MODE_ROW:     proj = longint'(row);
                MODE_COL:     proj = longint'(col);
                MODE_NEG_ROW: proj = -longint'(row);
                default: begin
                    acc = longint'(cos_q) * longint'(col) + longint'(sin_q) * longint'(row);
                    // truncate toward zero, not toward minus infinity
                    proj = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
                end
            endcase
            phase = proj + longint'(speed) * longint'(frame);
            rem = phase % period;
            if (rem < 0) begin
                rem += period;
            end
            return (2 * rem <= period) ? PIX_WHITE : PIX_BLACK;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                                 logic [TIME_W-1:0] frame);
            t_pixel_expect e;
            e.col   = col;
            e.row   = row;
            e.frame = frame;
            e.pixel = grating_pixel(col, row, frame);
            expected_pixels.push_back(e);
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] actual);
            t_pixel_expect e;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected pixel beat: got %h", actual));
                return;
            end
            e = expected_pixels.pop_front();
            if (actual !== e.pixel) begin
                report($sformatf("pixel mismatch col=%0d row=%0d t=%0d: expected %h got %h",
                                 e.col, e.row, e.frame, e.pixel, actual));
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr = '0;
    logic [APB_DATA_W-1:0]       pwdata = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [COORD_BITS-1:0]       i_pixel_col = '0;
    logic [COORD_BITS-1:0]       i_pixel_row = '0;
    logic [TIME_W-1:0]           i_frame_time = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b1;
    logic [PIX_W-1:0]            o_pixel_value;

    t_pixel_scoreboard sb = new();
    bit                src_idle_on = 1'b0;
    bit                sink_idle_on = 1'b0;
    int                sink_stall_left = 0;
    int                cycle_count = 0;

    drifting_square_grating_pixel_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_frame_time (i_frame_time),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_value(o_pixel_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("drifting_square_grating_pixel_top_tb NOT OK");
            $finish;
        end
    end

    // Output side: check each accepted beat, then pick the next ready level.
    always @(posedge i_clk) begin : sink
        logic ready_nxt;
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_pixel(o_pixel_value);
        end
        if (!sink_idle_on) begin
            sink_stall_left = 0;
        end
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            ready_nxt = 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            sink_stall_left = $urandom_range(1, 19) - 1;
            ready_nxt = 1'b0;
        end else begin
            ready_nxt = 1'b1;
        end
        i_ready <= ready_nxt;
    end

    // Setup and access cycle; psel is left high so writes can go back to back.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
    endtask

    // Keep the field in the low bits, sometimes with junk above it.
    function automatic logic [APB_DATA_W-1:0] with_junk(int value, int width);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] junk;
        mask = (APB_DATA_W'(1) << width) - 1;
        junk = $urandom();
        if ($urandom_range(0, 1) == 1) begin
            return (junk & ~mask) | (APB_DATA_W'(value) & mask);
        end
        return APB_DATA_W'(value) & mask;
    endfunction

    task automatic load_settings(input t_grating_settings s);
        apb_write(REG_DIRECTION_MODE, with_junk(s.mode, MODE_W));
        apb_write(REG_COS_COEF, with_junk(s.cos_q, COEF_W));
        apb_write(REG_SIN_COEF, with_junk(s.sin_q, COEF_W));
        apb_write(REG_WAVE_LENGTH, with_junk(s.wave_len, WL_W));
        apb_write(REG_DRIFT_SPEED, with_junk(s.speed, SPEED_W));
        // unmapped index: the write must leave every register alone
        apb_write(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row,
                              input logic [TIME_W-1:0] frame);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel_col  <= col;
        i_pixel_row  <= row;
        i_frame_time <= frame;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(col, row, frame);
    endtask

    task automatic send_corners();
        send_pixel('0, '0, '0);
        send_pixel(COORD_MAX, COORD_MAX, TIME_MAX);
        send_pixel(COORD_MAX, '0, TIME_MAX);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_coef();
        case ($urandom_range(0, 5))
            0:       return -16384;
            1:       return 16384;
            2:       return int'($signed(16'($urandom())));
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic t_grating_settings pick_settings();
        t_grating_settings s;
        if ($urandom_range(0, 9) < 4) begin
            s.mode = MODE_W'($urandom_range(MODE_NEG_COL, MODE_NEG_ROW));
        end else begin
            s.mode = MODE_W'($urandom_range(MODE_GENERAL, MODE_LAST));
        end
        s.cos_q = pick_coef();
        s.sin_q = pick_coef();
        case ($urandom_range(0, 15))
            0:       s.wave_len = 1;
            1:       s.wave_len = 4095;
            2:       s.wave_len = 0;
            3, 4, 5: s.wave_len = $urandom_range(0, 4095);
            default: s.wave_len = $urandom_range(2, 64);
        endcase
        case ($urandom_range(0, 9))
            0:       s.speed = -4095;
            1:       s.speed = 4095;
            2:       s.speed = 0;
            3:       s.speed = -4096;
            default: s.speed = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return s;
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        if ($urandom_range(0, 9) == 0) begin
            return ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
        end
        return COORD_BITS'($urandom());
    endfunction

    initial begin : stimulus
        t_grating_settings directed[7];
        int                sent;
        int                n;
        directed[0] = '{MODE_NEG_COL, 16384, 0, 4095, -4095};
        directed[1] = '{MODE_ROW, 0, 16384, 1, 4095};
        directed[2] = '{MODE_NEG_ROW, 0, 0, 0, -1};          // zero wavelength
        directed[3] = '{MODE_GENERAL, -16384, 16384, 2, 1};
        directed[4] = '{3'd5, -32768, 32767, 4095, -4095};   // coefficients past +-1.0
        directed[5] = '{3'd6, 32767, -32768, 7, 4095};
        directed[6] = '{MODE_LAST, 11585, -11585, 33, -3};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first, then each directed setting
        send_corners();
        drain();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (directed[k]) begin
            load_settings(directed[k]);
            send_corners();
            drain();
        end

        sent = 0;
        while (sent < ITEM_TARGET) begin
            if (sent >= TAIL_START) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end else begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            load_settings(pick_settings());
            n = $urandom_range(20, 120);
            repeat (n) begin
                send_pixel(pick_coord(), pick_coord(), ($urandom_range(0, 9) == 0) ?
                           TIME_MAX : TIME_W'($urandom()));
            end
            sent += n;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("drifting_square_grating_pixel_top_tb OK");
        end else begin
            $display("drifting_square_grating_pixel_top_tb NOT OK");
        end
        $finish;
    end

endmodule
